>>> hdl/rxr_pkg.sv
`timescale 1ns / 1ps

package rxr_pkg;

    localparam int SLOT_W    = 6;
    localparam int TALLY_W   = 10;
    localparam int SERVED_W  = 6;
    localparam int CNT_W     = 32;
    localparam int LEN_W     = 14;
    localparam int BCOUNT_W  = 4;
    localparam int BINDEX_W  = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 14;

    localparam logic [LEN_W-1:0] CRC_BYTES = 14'd4;

    localparam logic [1:0] ACT_DELIVER = 2'd0;
    localparam logic [1:0] ACT_DROP    = 2'd1;
    localparam logic [1:0] ACT_STOP    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BATCH_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH  = 2'd2;

    localparam logic                 ENABLE_RST      = 1'b1;
    localparam logic [SERVED_W-1:0]  BATCH_LIMIT_RST = 6'd32;
    localparam logic [LEN_W-1:0]     MAX_LENGTH_RST  = 14'd1536;

    typedef struct packed {
        logic                new_poll;
        logic                updated;
        logic [BCOUNT_W-1:0] buffer_count;
        logic [BINDEX_W-1:0] buffer_index;
        logic [LEN_W-1:0]    packet_length;
        logic                error_summary;
        logic                length_error;
    } desc_req_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [SLOT_W-1:0] deliver_slot;
        logic [LEN_W-1:0]  frame_length;
        logic [SLOT_W-1:0] head_slot;
        logic              publish;
        logic [SLOT_W-1:0] producer_index;
        logic [CNT_W-1:0]  delivered_total;
        logic [CNT_W-1:0]  dropped_total;
    } result_req_t;

endpackage

>>> hdl/rxr_if.sv
`timescale 1ns / 1ps

interface rxr_desc_if;
    logic                valid;
    logic                ready;
    rxr_pkg::desc_req_t  req;

    modport source (output valid, output req, input ready);
    modport sink (input valid, input req, output ready);
endinterface

interface rxr_result_if;
    logic                 valid;
    logic                 ready;
    rxr_pkg::result_req_t req;

    modport source (output valid, output req, input ready);
    modport sink (input valid, input req, output ready);
endinterface

>>> hdl/rx_return_ring_consumer.sv
`timescale 1ns / 1ps

// Takes one receive return descriptor request per clock cycle unless results stall, and
// gives one result request for each: the request is captured in an input register, the
// ring head, tallies and counters are updated by short logic, and the result sits in an
// output register until it is taken, while the next descriptor is accepted behind it. The
// ring state is held in flip-flops, so the block is ready right after reset with no clearing
// pass. Configuration writes are taken on any cycle but must only be made while idle.

module rx_return_ring_consumer #(
    parameter int RING_SLOTS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    rxr_desc_if.sink                             desc,
    rxr_result_if.source                         result,
    input  logic                                 cfg_we,
    input  logic [rxr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rxr_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int PW = (RING_SLOTS > 2) ? $clog2(RING_SLOTS) : 1;
    localparam logic [PW:0] RMOD = (PW+1)'(RING_SLOTS);
    localparam logic [rxr_pkg::BINDEX_W:0] RLIM = (rxr_pkg::BINDEX_W+1)'(RING_SLOTS);
    localparam int WRAP_MOD = (1 << rxr_pkg::TALLY_W) % RING_SLOTS;

    logic                          enable_reg;
    logic [rxr_pkg::SERVED_W-1:0]  batch_limit_reg;
    logic [rxr_pkg::LEN_W-1:0]     max_length_reg;

    logic                          s1_valid_reg;
    rxr_pkg::desc_req_t            s1_req_reg;
    logic                          res_valid_reg;
    rxr_pkg::result_req_t          res_req_reg;
    rxr_pkg::result_req_t          res_req_next;

    logic [PW-1:0]                 head_reg, head_next;
    logic [PW-1:0]                 prod_reg, prod_next;
    logic [rxr_pkg::TALLY_W-1:0]   tally_reg, tally_next;
    logic [PW-1:0]                 resid_reg, resid_next;
    logic [rxr_pkg::SERVED_W-1:0]  served_reg, served_next;
    logic                          closed_reg, closed_next;
    logic [rxr_pkg::CNT_W-1:0]     delivered_reg, delivered_next;
    logic [rxr_pkg::CNT_W-1:0]     dropped_reg, dropped_next;

    logic                          s1_advance;

    logic [rxr_pkg::TALLY_W-1:0]   tally_eff;
    logic [PW-1:0]                 resid_eff;
    logic [rxr_pkg::SERVED_W-1:0]  served_eff;
    logic                          closed_eff;
    logic [rxr_pkg::BCOUNT_W-1:0]  inc;
    logic [rxr_pkg::TALLY_W:0]     tally_sum;
    logic [PW-1:0]                 delta;
    logic [PW-1:0]                 resid_new;
    logic [rxr_pkg::SERVED_W-1:0]  served_new;
    logic [rxr_pkg::SERVED_W-1:0]  limit;
    logic                          ok;

    // Residues of each buffer increment modulo the ring size, without and with a tally wrap.
    logic [PW-1:0]                 inc_mod [16];
    logic [PW-1:0]                 inc_wrap_mod [16];

    for (genvar k = 0; k < 16; k++)
    begin : g_inc
        localparam int KM  = k % RING_SLOTS;
        localparam int KWM = (KM + RING_SLOTS - WRAP_MOD) % RING_SLOTS;
        assign inc_mod[k]      = PW'(KM);
        assign inc_wrap_mod[k] = PW'(KWM);
    end

    function automatic logic [PW-1:0] mod_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
        logic [PW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= RMOD)
        begin
            s = s - RMOD;
        end
        return s[PW-1:0];
    endfunction

    assign s1_advance   = s1_valid_reg && (!res_valid_reg || result.ready);
    assign desc.ready   = !s1_valid_reg || s1_advance;
    assign result.valid = res_valid_reg;
    assign result.req   = res_req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= rxr_pkg::ENABLE_RST;
            batch_limit_reg <= rxr_pkg::BATCH_LIMIT_RST;
            max_length_reg  <= rxr_pkg::MAX_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rxr_pkg::REG_ENABLE:      enable_reg      <= cfg_data[0];
                rxr_pkg::REG_BATCH_LIMIT: batch_limit_reg <= cfg_data[rxr_pkg::SERVED_W-1:0];
                rxr_pkg::REG_MAX_LENGTH:  max_length_reg  <= cfg_data[rxr_pkg::LEN_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        head_next      = head_reg;
        prod_next      = prod_reg;
        tally_next     = tally_reg;
        resid_next     = resid_reg;
        served_next    = served_reg;
        closed_next    = closed_reg;
        delivered_next = delivered_reg;
        dropped_next   = dropped_reg;

        res_req_next              = '0;
        res_req_next.action       = rxr_pkg::ACT_STOP;

        tally_eff  = s1_req_reg.new_poll ? '0 : tally_reg;
        resid_eff  = s1_req_reg.new_poll ? '0 : resid_reg;
        served_eff = s1_req_reg.new_poll ? '0 : served_reg;
        closed_eff = s1_req_reg.new_poll ? 1'b0 : closed_reg;

        inc        = (s1_req_reg.buffer_count == '0) ? 4'd1 : s1_req_reg.buffer_count;
        tally_sum  = {1'b0, tally_eff} + (rxr_pkg::TALLY_W+1)'(inc);
        delta      = tally_sum[rxr_pkg::TALLY_W] ? inc_wrap_mod[inc] : inc_mod[inc];
        resid_new  = mod_add(resid_eff, delta);
        served_new = served_eff + 6'd1;
        limit      = (batch_limit_reg == '0) ? 6'd1 : batch_limit_reg;

        ok = (s1_req_reg.buffer_count == 4'd1)
            && ({1'b0, s1_req_reg.buffer_index} < RLIM)
            && !s1_req_reg.error_summary && !s1_req_reg.length_error
            && (s1_req_reg.packet_length > rxr_pkg::CRC_BYTES)
            && (s1_req_reg.packet_length <= max_length_reg);

        if (enable_reg)
        begin
            tally_next  = tally_eff;
            resid_next  = resid_eff;
            served_next = served_eff;
            closed_next = closed_eff;
            if (!closed_eff)
            begin
                if (!s1_req_reg.updated)
                begin
                    closed_next = 1'b1;
                    if (tally_eff != '0)
                    begin
                        prod_next            = mod_add(prod_reg, resid_eff);
                        res_req_next.publish = 1'b1;
                    end
                end
                else
                begin
                    if (ok)
                    begin
                        res_req_next.action       = rxr_pkg::ACT_DELIVER;
                        res_req_next.deliver_slot = s1_req_reg.buffer_index[rxr_pkg::SLOT_W-1:0];
                        res_req_next.frame_length = s1_req_reg.packet_length - rxr_pkg::CRC_BYTES;
                        delivered_next            = delivered_reg + 32'd1;
                    end
                    else
                    begin
                        res_req_next.action = rxr_pkg::ACT_DROP;
                        dropped_next        = dropped_reg + 32'd1;
                    end
                    head_next   = (head_reg == PW'(RING_SLOTS - 1)) ? '0 : head_reg + PW'(1);
                    tally_next  = tally_sum[rxr_pkg::TALLY_W-1:0];
                    resid_next  = resid_new;
                    served_next = served_new;
                    if (served_new >= limit)
                    begin
                        closed_next = 1'b1;
                        if (tally_sum[rxr_pkg::TALLY_W-1:0] != '0)
                        begin
                            prod_next            = mod_add(prod_reg, resid_new);
                            res_req_next.publish = 1'b1;
                        end
                    end
                end
            end
        end

        res_req_next.head_slot       = rxr_pkg::SLOT_W'(head_next);
        res_req_next.producer_index  = rxr_pkg::SLOT_W'(prod_next);
        res_req_next.delivered_total = delivered_next;
        res_req_next.dropped_total   = dropped_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            head_reg      <= '0;
            prod_reg      <= PW'(RING_SLOTS - 1);
            tally_reg     <= '0;
            resid_reg     <= '0;
            served_reg    <= '0;
            closed_reg    <= 1'b0;
            delivered_reg <= '0;
            dropped_reg   <= '0;
        end
        else
        begin
            if (desc.ready)
            begin
                s1_valid_reg <= desc.valid;
            end
            if (s1_advance)
            begin
                res_valid_reg <= 1'b1;
                head_reg      <= head_next;
                prod_reg      <= prod_next;
                tally_reg     <= tally_next;
                resid_reg     <= resid_next;
                served_reg    <= served_next;
                closed_reg    <= closed_next;
                delivered_reg <= delivered_next;
                dropped_reg   <= dropped_next;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc.valid && desc.ready)
        begin
            s1_req_reg <= desc.req;
        end
        if (s1_advance)
        begin
            res_req_reg <= res_req_next;
        end
    end

endmodule

>>> hdl/rxr_checker.sv
`timescale 1ns / 1ps

module rxr_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  logic                 res_ready,
    input  rxr_pkg::result_req_t res_req
);

    // A stalled result request stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result request withdrawn while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_req))
        else $error("result payload changed while stalled");

    // Slot and length are only meaningful on a delivered packet.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_req.action != rxr_pkg::ACT_DELIVER)
            |-> (res_req.deliver_slot == '0) && (res_req.frame_length == '0))
        else $error("slot or length set on a result that is not a delivery");

    // Reset leaves no result pending.
    assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

endmodule

bind rx_return_ring_consumer rxr_checker u_rxr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_req   (result.req)
);

>>> tb/rx_return_ring_consumer_tb.sv
`timescale 1ns / 1ps

module rx_return_ring_consumer_tb;

    localparam int SLOTS = 64;
    localparam int CYCLE_LIMIT = 400000;

    class return_ring_mirror;
        bit                           enabled;
        logic [rxr_pkg::SERVED_W-1:0] batch_cap;
        logic [rxr_pkg::LEN_W-1:0]    length_cap;
        logic [rxr_pkg::SLOT_W-1:0]   head;
        logic [rxr_pkg::SLOT_W-1:0]   producer;
        logic [rxr_pkg::TALLY_W-1:0]  returned;
        logic [rxr_pkg::SERVED_W-1:0] served;
        bit                           closed;
        logic [rxr_pkg::CNT_W-1:0]    delivered;
        logic [rxr_pkg::CNT_W-1:0]    dropped;
        rxr_pkg::result_req_t         pending_results[$];
        int                           failures;

        function new();
            enabled    = rxr_pkg::ENABLE_RST;
            batch_cap  = rxr_pkg::BATCH_LIMIT_RST;
            length_cap = rxr_pkg::MAX_LENGTH_RST;
            head       = '0;
            producer   = rxr_pkg::SLOT_W'(SLOTS - 1);
            returned   = '0;
            served     = '0;
            closed     = 1'b0;
            delivered  = '0;
            dropped    = '0;
            failures   = 0;
        endfunction

        function void write_reg(logic [rxr_pkg::CFG_IDX_W-1:0] idx,
                                logic [rxr_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                rxr_pkg::REG_ENABLE:      enabled = data[0];
                rxr_pkg::REG_BATCH_LIMIT: batch_cap = data[rxr_pkg::SERVED_W-1:0];
                rxr_pkg::REG_MAX_LENGTH:  length_cap = data[rxr_pkg::LEN_W-1:0];
                default:                  ;
            endcase
        endfunction

        function bit end_batch();
            closed = 1'b1;
            if (returned == '0)
                return 1'b0;
            producer = producer + returned[rxr_pkg::SLOT_W-1:0];
            return 1'b1;
        endfunction

        // Predicts the result of one accepted descriptor request.
        function void note_descriptor(rxr_pkg::desc_req_t d);
            rxr_pkg::result_req_t         r;
            logic [rxr_pkg::SERVED_W-1:0] lim;
            bit                           good;
            r = '0;
            r.action = rxr_pkg::ACT_STOP;
            if (enabled)
            begin
                if (d.new_poll)
                begin
                    served = '0;
                    returned = '0;
                    closed = 1'b0;
                end
                if (!closed)
                begin
                    if (!d.updated)
                    begin
                        r.publish = end_batch();
                    end
                    else
                    begin
                        lim = (batch_cap == '0) ? rxr_pkg::SERVED_W'(1) : batch_cap;
                        good = (d.buffer_count == 4'd1)
                            && (d.buffer_index < rxr_pkg::BINDEX_W'(SLOTS))
                            && !d.error_summary && !d.length_error
                            && (d.packet_length > rxr_pkg::CRC_BYTES)
                            && (d.packet_length <= length_cap);
                        if (good)
                        begin
                            r.action = rxr_pkg::ACT_DELIVER;
                            r.deliver_slot = d.buffer_index[rxr_pkg::SLOT_W-1:0];
                            r.frame_length = d.packet_length - rxr_pkg::CRC_BYTES;
                            delivered = delivered + 32'd1;
                        end
                        else
                        begin
                            r.action = rxr_pkg::ACT_DROP;
                            dropped = dropped + 32'd1;
                        end
                        head = head + rxr_pkg::SLOT_W'(1);
                        returned = returned + rxr_pkg::TALLY_W'((d.buffer_count == '0)
                                                                ? 4'd1 : d.buffer_count);
                        served = served + rxr_pkg::SERVED_W'(1);
                        if (served >= lim)
                            r.publish = end_batch();
                    end
                end
            end
            r.head_slot = head;
            r.producer_index = producer;
            r.delivered_total = delivered;
            r.dropped_total = dropped;
            pending_results.push_back(r);
        endfunction

        function void check_result(rxr_pkg::result_req_t got);
            rxr_pkg::result_req_t want;
            if (pending_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("result request with nothing outstanding: action=%0d head=%0d",
                             got.action, got.head_slot);
                return;
            end
            want = pending_results.pop_front();
            if (got.action !== want.action || got.deliver_slot !== want.deliver_slot ||
                got.frame_length !== want.frame_length || got.head_slot !== want.head_slot ||
                got.publish !== want.publish || got.producer_index !== want.producer_index ||
                got.delivered_total !== want.delivered_total ||
                got.dropped_total !== want.dropped_total)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("mismatch expected: act=%0d slot=%0d len=%0d head=%0d pub=%0d",
                             want.action, want.deliver_slot, want.frame_length,
                             want.head_slot, want.publish);
                    $display("                   prod=%0d dlv=%0d drp=%0d",
                             want.producer_index, want.delivered_total, want.dropped_total);
                    $display("         actual:   act=%0d slot=%0d len=%0d head=%0d pub=%0d",
                             got.action, got.deliver_slot, got.frame_length,
                             got.head_slot, got.publish);
                    $display("                   prod=%0d dlv=%0d drp=%0d",
                             got.producer_index, got.delivered_total, got.dropped_total);
                end
            end
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [rxr_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rxr_pkg::CFG_DATA_W-1:0] cfg_data;
    int                             cycles = 0;
    return_ring_mirror              sb;

    rxr_desc_if   desc_ch ();
    rxr_result_if res_ch ();

    rx_return_ring_consumer #(
        .RING_SLOTS(SLOTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .desc      (desc_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic rxr_pkg::desc_req_t mk(int np, int upd, int cnt, int idx, int len,
                                              int es, int le);
        rxr_pkg::desc_req_t d;
        d.new_poll = (np != 0);
        d.updated = (upd != 0);
        d.buffer_count = rxr_pkg::BCOUNT_W'(cnt);
        d.buffer_index = rxr_pkg::BINDEX_W'(idx);
        d.packet_length = rxr_pkg::LEN_W'(len);
        d.error_summary = (es != 0);
        d.length_error = (le != 0);
        return d;
    endfunction

    function automatic rxr_pkg::desc_req_t random_desc(bit first);
        rxr_pkg::desc_req_t        d;
        logic [rxr_pkg::LEN_W-1:0] ceiling;
        ceiling = sb.length_cap;
        d.new_poll = first ? 1'b1 : ($urandom_range(0, 39) == 0);
        d.updated = ($urandom_range(0, 15) != 0);
        if ($urandom_range(0, 9) < 7 && ceiling > rxr_pkg::CRC_BYTES)
        begin
            d.buffer_count = 4'd1;
            d.buffer_index = rxr_pkg::BINDEX_W'($urandom_range(0, SLOTS - 1));
            case ($urandom_range(0, 9))
                0:       d.packet_length = ceiling;
                1:       d.packet_length = rxr_pkg::LEN_W'(5);
                2:       d.packet_length = (ceiling == '1) ? ceiling
                                                           : ceiling + rxr_pkg::LEN_W'(1);
                default: d.packet_length = rxr_pkg::LEN_W'($urandom_range(5, int'(ceiling)));
            endcase
            d.error_summary = 1'b0;
            d.length_error = 1'b0;
        end
        else
        begin
            d.buffer_count = rxr_pkg::BCOUNT_W'($urandom_range(0, 15));
            d.buffer_index = ($urandom_range(0, 1) == 0)
                ? rxr_pkg::BINDEX_W'($urandom_range(0, SLOTS - 1))
                : rxr_pkg::BINDEX_W'($urandom_range(0, 4095));
            d.packet_length = rxr_pkg::LEN_W'($urandom_range(0, 16383));
            d.error_summary = ($urandom_range(0, 2) == 0);
            d.length_error = ($urandom_range(0, 2) == 0);
        end
        return d;
    endfunction

    task automatic push(input rxr_pkg::desc_req_t d);
        int gap;
        gap = $urandom_range(0, 14);
        if (gap > 0)
        begin
            desc_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        desc_ch.valid <= 1'b1;
        desc_ch.req <= d;
        do @(posedge clk); while (!desc_ch.ready);
        sb.note_descriptor(d);
    endtask

    task automatic settle();
        desc_ch.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(input logic [rxr_pkg::CFG_IDX_W-1:0] idx, input int data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= rxr_pkg::CFG_DATA_W'(data);
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, rxr_pkg::CFG_DATA_W'(data));
    endtask

    task automatic run_traffic(input int target);
        int                 sent;
        int                 left;
        rxr_pkg::desc_req_t d;
        sent = 0;
        left = 0;
        while (sent < target)
        begin
            d = random_desc(left == 0);
            if (left == 0)
                left = $urandom_range(1, int'(sb.batch_cap) + 6);
            left--;
            push(d);
            sent++;
        end
    endtask

    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(0, 14);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            sb.check_result(res_ch.req);
        end
    end

    initial
    begin : stimulus
        sb = new();
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        desc_ch.valid <= 1'b0;
        desc_ch.req <= '0;
        res_ch.ready <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        push(mk(1, 1, 1, 0, 5, 0, 0));
        push(mk(0, 1, 1, 63, 1536, 0, 0));
        push(mk(0, 1, 1, 10, 1537, 0, 0));
        push(mk(0, 1, 1, 10, 4, 0, 0));
        push(mk(0, 1, 1, 10, 0, 0, 0));
        push(mk(0, 1, 0, 10, 100, 0, 0));
        push(mk(0, 1, 15, 4095, 16383, 1, 1));
        push(mk(0, 1, 1, 64, 100, 0, 0));
        push(mk(0, 1, 1, 5, 100, 1, 0));
        push(mk(0, 1, 1, 5, 100, 0, 1));
        push(mk(0, 1, 2, 5, 100, 0, 0));
        push(mk(0, 0, 0, 0, 0, 0, 0));
        push(mk(0, 1, 1, 1, 60, 0, 0));
        push(mk(1, 0, 1, 1, 60, 0, 0));
        push(mk(1, 1, 1, 2, 60, 0, 0));
        settle();
        set_reg(rxr_pkg::REG_BATCH_LIMIT, 1);
        set_reg(rxr_pkg::REG_MAX_LENGTH, 16383);
        push(mk(1, 1, 1, 3, 16383, 0, 0));
        push(mk(0, 1, 1, 3, 16383, 0, 0));
        settle();
        set_reg(rxr_pkg::REG_BATCH_LIMIT, 0);
        push(mk(1, 1, 3, 4, 70, 0, 0));
        settle();
        set_reg(rxr_pkg::REG_BATCH_LIMIT, 63);
        set_reg(rxr_pkg::REG_MAX_LENGTH, 5);
        push(mk(1, 1, 1, 4, 5, 0, 0));
        push(mk(0, 1, 1, 4, 6, 0, 0));
        settle();
        set_reg(rxr_pkg::REG_ENABLE, 0);
        push(mk(1, 1, 1, 4, 5, 0, 0));
        push(mk(0, 0, 1, 4, 5, 0, 0));
        settle();
        set_reg(rxr_pkg::REG_ENABLE, 1);

        for (int phase = 0; phase < 8; phase++)
        begin
            settle();
            case (phase)
                0:       set_reg(rxr_pkg::REG_BATCH_LIMIT, 63);
                1:       set_reg(rxr_pkg::REG_BATCH_LIMIT, 1);
                default: set_reg(rxr_pkg::REG_BATCH_LIMIT, int'($urandom_range(1, 63)));
            endcase
            case (phase)
                0:       set_reg(rxr_pkg::REG_MAX_LENGTH, 1536);
                2:       set_reg(rxr_pkg::REG_MAX_LENGTH, 5);
                3:       set_reg(rxr_pkg::REG_MAX_LENGTH, 16383);
                default: set_reg(rxr_pkg::REG_MAX_LENGTH, int'($urandom_range(5, 16383)));
            endcase
            run_traffic(116);
        end
        settle();

        if (sb.failures == 0 && sb.pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
